// File: hdl/rrv_pkg.sv
// rrv_pkg: shared types, constants and fixed-point helpers for the
// rounded rectangle vertex generator; no dependencies
`timescale 1ns / 1ps
package rrv_pkg;

  localparam int QW = 31;

  localparam logic [QW-1:0] SIN_C1 = 31'd1686629713;
  localparam logic [QW-1:0] SIN_C3 = 31'd693598668;
  localparam logic [QW-1:0] SIN_C5 = 31'd85569306;
  localparam logic [QW-1:0] SIN_C7 = 31'd5026995;
  localparam logic [QW-1:0] SIN_C9 = 31'd172272;
  localparam logic [QW-1:0] Q30_ONE = 31'd1073741824;
  localparam logic [62:0] Q30_HALF = 63'd536870912;

  localparam logic [1:0] REG_BOX_WIDTH = 2'd0;
  localparam logic [1:0] REG_BOX_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CORNER_RADIUS = 2'd2;
  localparam logic [1:0] REG_MAX_POINTS = 2'd3;

  typedef struct packed {
    logic [1:0] side;
    logic arc;
    logic oor;
    logic signed [19:0] sx;
    logic signed [19:0] sy;
    logic [8:0] count;
  } rrv_meta_t;

  function automatic logic [QW-1:0] q30_mul(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic [62:0] pr;
    pr = 63'(a) * 63'(b) + Q30_HALF;
    return pr[60:30];
  endfunction

endpackage

// File: hdl/rrv_div_cell.sv
// rrv_div_cell: one restoring division step for the two arc fractions
// depends on rrv_pkg
`timescale 1ns / 1ps
module rrv_div_cell import rrv_pkg::*; #(
  parameter int NW = 7
) (
  input  logic clk,
  input  logic en,
  input  logic [NW-1:0] d,
  input  logic [NW-1:0] rem_t_in,
  input  logic bit_t_in,
  input  logic [QW-1:0] q_t_in,
  input  logic [NW-1:0] rem_u_in,
  input  logic bit_u_in,
  input  logic [QW-1:0] q_u_in,
  input  rrv_meta_t meta_in,
  output logic [NW-1:0] rem_t_out,
  output logic [QW-1:0] q_t_out,
  output logic [NW-1:0] rem_u_out,
  output logic [QW-1:0] q_u_out,
  output rrv_meta_t meta_out
);

  logic [NW:0] rt, ru, rt_sub, ru_sub;
  logic ge_t, ge_u;

  always_comb begin
    rt = {rem_t_in, bit_t_in};
    ru = {rem_u_in, bit_u_in};
    ge_t = rt >= {1'b0, d};
    ge_u = ru >= {1'b0, d};
    rt_sub = rt - {1'b0, d};
    ru_sub = ru - {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_t_out <= ge_t ? rt_sub[NW-1:0] : rt[NW-1:0];
      rem_u_out <= ge_u ? ru_sub[NW-1:0] : ru[NW-1:0];
      q_t_out <= {q_t_in[QW-2:0], ge_t};
      q_u_out <= {q_u_in[QW-2:0], ge_u};
      meta_out <= meta_in;
    end
  end

endmodule

// File: hdl/rrv_sine.sv
// rrv_sine: seven-stage quarter-wave sine polynomial scaled by the radius
// depends on rrv_pkg
`timescale 1ns / 1ps
module rrv_sine import rrv_pkg::*; (
  input  logic clk,
  input  logic en,
  input  logic [QW-1:0] t,
  input  logic [15:0] r,
  output logic [15:0] mag
);

  logic [QW-1:0] t1, t2_1, t2, t2_2, p2, t3, t2_3, p3, t4, t2_4, p4, t5, p5, p6, p6c;
  logic [47:0] pr;

  always_comb begin
    p6c = q30_mul(t5, p5);
    if (p6c > Q30_ONE) p6c = Q30_ONE;
    pr = 48'(p6) * 48'(r) + 48'(Q30_HALF);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= t;
      t2_1 <= q30_mul(t, t);
      t2 <= t1;
      t2_2 <= t2_1;
      p2 <= SIN_C7 - q30_mul(t2_1, SIN_C9);
      t3 <= t2;
      t2_3 <= t2_2;
      p3 <= SIN_C5 - q30_mul(t2_2, p2);
      t4 <= t3;
      t2_4 <= t2_3;
      p4 <= SIN_C3 - q30_mul(t2_3, p3);
      t5 <= t4;
      p5 <= SIN_C1 - q30_mul(t2_4, p4);
      p6 <= p6c;
      mag <= pr[45:30];
    end
  end

endmodule

// File: hdl/rounded_rect_vertex_gen_unit.sv
// rounded_rect_vertex_gen_unit: top level of the rounded rectangle vertex generator
// depends on rrv_pkg, rrv_div_cell, rrv_sine
//
// usage:
//   s_tdata[8:0] carries a vertex index; one beat in gives one beat out.
//   m_tdata holds point_x[17:0], point_y[35:18], point_count[44:36];
//   m_tuser is out_of_range (coordinates read zero when set).
//   the cfg port writes box_width (0), box_height (1), corner_radius (2)
//   and max_corner_points (3); write only while no beat is in flight.
// the pipeline holds one decode stage, a row of 31 divider cells (one
// quotient bit each for the two arc angles), seven multiply stages of the
// sine polynomial and one output register.
// throughput is one beat per cycle while the receiver keeps up; the whole row advances together.
// when the receiver stalls with a beat held at the output, the row freezes
// and s_tready drops in the same cycle; no beat is lost or repeated.
// reset is synchronous: it empties the row and restores the registers
// (max_corner_points to 10, the others to 0).
`timescale 1ns / 1ps
module rounded_rect_vertex_gen_unit import rrv_pkg::*; #(
  parameter int CORNER_POINTS_LIMIT = 64,
  parameter int FRAC_BITS = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [15:0] s_tdata,   // vertex_index
  output logic m_tvalid,
  input  logic m_tready,
  output logic [47:0] m_tdata,   // point_x, point_y, point_count
  output logic m_tuser,          // out_of_range
  input  logic cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [15:0] cfg_data
);

  localparam int NW = $clog2(CORNER_POINTS_LIMIT + 1);
  localparam int CW = NW + 10;
  localparam int NCELL = QW;
  localparam int SDLY = 7;
  localparam int LAT = NCELL + SDLY + 2;
  localparam logic [23:0] HALF = 24'((1 << FRAC_BITS) >> 1);

  logic [15:0] box_width, box_height, corner_radius;
  logic [6:0] max_corner_points;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_width <= '0;
      box_height <= '0;
      corner_radius <= '0;
      max_corner_points <= 7'd10;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BOX_WIDTH: box_width <= cfg_data;
        REG_BOX_HEIGHT: box_height <= cfg_data;
        REG_CORNER_RADIUS: corner_radius <= cfg_data;
        REG_MAX_POINTS: max_corner_points <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic [LAT-1:0] vld;

  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[LAT-2:0], s_tvalid};
  end

  // decode
  logic [NW-1:0] cap, n, d, sub_n, k, dk;
  logic [23:0] lim, nr;
  logic [CW-1:0] p1, p2, p3, p4, idx_w, base, sub;
  logic ge1, ge2, ge3, oor, arc, neg;
  logic [1:0] side;
  logic [2:0] s;
  logic signed [19:0] bx, by, rr;
  rrv_meta_t meta_a;

  always_comb begin
    cap = (8'(max_corner_points) > 8'(CORNER_POINTS_LIMIT)) ?
          NW'(CORNER_POINTS_LIMIT) : max_corner_points[NW-1:0];
    lim = 24'(cap) << FRAC_BITS;
    nr = (24'(corner_radius) + HALF) >> FRAC_BITS;
    n = (24'(corner_radius) < lim) ? nr[NW-1:0] : cap;
    d = n - 1'b1;
    p1 = CW'(n) + 1'b1;
    p2 = p1 << 1;
    p3 = p1 + p2;
    p4 = p1 << 2;
    idx_w = CW'(s_tdata[8:0]);
    ge1 = idx_w >= p1;
    ge2 = idx_w >= p2;
    ge3 = idx_w >= p3;
    oor = idx_w >= p4;
    side = 2'(ge1) + 2'(ge2) + 2'(ge3);
    base = ge3 ? p3 : (ge2 ? p2 : (ge1 ? p1 : '0));
    sub = idx_w - base;
    sub_n = sub[NW-1:0];
    arc = !oor && (sub >= CW'(2));
    k = arc ? sub_n - 1'b1 : '0;
    dk = arc ? d - k : '0;
    s = 3'(side) + 3'(sub_n[0]);
    bx = (s == 3'd1 || s == 3'd2) ? 20'(box_width) : 20'sd0;
    by = (s == 3'd2 || s == 3'd3) ? 20'(box_height) : 20'sd0;
    neg = side[1] ^ sub_n[0];
    rr = neg ? -20'(corner_radius) : 20'(corner_radius);
    meta_a.side = side;
    meta_a.arc = arc;
    meta_a.oor = oor;
    meta_a.sx = side[0] ? bx : bx + rr;
    meta_a.sy = side[0] ? by + rr : by;
    meta_a.count = p4[8:0];
  end

  logic [NW-1:0] rem_t [0:NCELL];
  logic [NW-1:0] rem_u [0:NCELL];
  logic [QW-1:0] q_t [0:NCELL];
  logic [QW-1:0] q_u [0:NCELL];
  rrv_meta_t meta_c [0:NCELL];
  logic bit_t0, bit_u0;

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_t[0] <= k >> 1;
      rem_u[0] <= dk >> 1;
      bit_t0 <= k[0];
      bit_u0 <= dk[0];
      q_t[0] <= '0;
      q_u[0] <= '0;
      meta_c[0] <= meta_a;
    end
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    rrv_div_cell #(.NW(NW)) u_cell (
      .clk(clk),
      .en(adv),
      .d(d),
      .rem_t_in(rem_t[i]),
      .bit_t_in(i == 0 ? bit_t0 : 1'b0),
      .q_t_in(q_t[i]),
      .rem_u_in(rem_u[i]),
      .bit_u_in(i == 0 ? bit_u0 : 1'b0),
      .q_u_in(q_u[i]),
      .meta_in(meta_c[i]),
      .rem_t_out(rem_t[i+1]),
      .q_t_out(q_t[i+1]),
      .rem_u_out(rem_u[i+1]),
      .q_u_out(q_u[i+1]),
      .meta_out(meta_c[i+1])
    );
  end

  logic [15:0] sa, ca;

  rrv_sine u_sin (.clk(clk), .en(adv), .t(q_t[NCELL]), .r(corner_radius), .mag(sa));
  rrv_sine u_cos (.clk(clk), .en(adv), .t(q_u[NCELL]), .r(corner_radius), .mag(ca));

  rrv_meta_t meta_d [0:SDLY-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_d[0] <= meta_c[NCELL];
      for (int j = 1; j < SDLY; j++) meta_d[j] <= meta_d[j-1];
    end
  end

  function automatic logic [17:0] sat18(input logic signed [19:0] v);
    if (v > 20'sd131071) return 18'h1ffff;
    if (v < -20'sd131072) return 18'h20000;
    return v[17:0];
  endfunction

  rrv_meta_t mo;
  logic signed [19:0] sv, cv, cx, cy, x, y, rs, sas, cas;

  always_comb begin
    mo = meta_d[SDLY-1];
    rs = 20'(corner_radius);
    sas = 20'(sa);
    cas = 20'(ca);
    case (mo.side)
      2'd0: begin sv = sas; cv = cas; end
      2'd1: begin sv = cas; cv = -sas; end
      2'd2: begin sv = -sas; cv = -cas; end
      default: begin sv = -cas; cv = sas; end
    endcase
    cx = mo.side[1] ? rs : 20'(box_width) - rs;
    cy = (mo.side == 2'd1 || mo.side == 2'd2) ? 20'(box_height) - rs : rs;
    if (mo.oor) begin
      x = '0;
      y = '0;
    end else if (mo.arc) begin
      x = cx + sv;
      y = cy - cv;
    end else begin
      x = mo.sx;
      y = mo.sy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {3'b000, mo.count, sat18(y), sat18(x)};
      m_tuser <= mo.oor;
    end
  end

endmodule

// File: tb/testbench.sv
// testbench: checks rounded_rect_vertex_gen_unit against a behavioral predictor
// of the vertex geometry; depends on rrv_pkg and the top level
`timescale 1ns / 1ps
module testbench;
  import rrv_pkg::*;

  localparam int LIMIT = 64;
  localparam int WATCHDOG = 4000;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [15:0] s_tdata = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [47:0] m_tdata;
  logic m_tuser;
  logic cfg_we = 0;
  logic [1:0] cfg_addr = 0;
  logic [15:0] cfg_data = 0;

  typedef struct packed {
    logic [17:0] px;
    logic [17:0] py;
    logic [8:0] cnt;
    logic oor;
  } vertex_t;

  typedef struct {
    logic [15:0] idx;
    logic chk;
    vertex_t v;
  } dir_row_t;

  vertex_t vertex_q[$];
  int errors = 0;
  int stall_cnt = 0;
  int send_idle = 13;
  int recv_idle = 79;
  logic [15:0] wd, ht, rad;
  logic [6:0] maxp;

  rounded_rect_vertex_gen_unit u_top (.*);

  always #10 clk = ~clk;

  function automatic longint qmul(longint a, longint b);
    return (a * b + 64'd536870912) >>> 30;
  endfunction

  function automatic longint qsine(longint t);
    longint t2, p;
    t2 = qmul(t, t);
    p = 5026995 - qmul(t2, 172272);
    p = 85569306 - qmul(t2, p);
    p = 693598668 - qmul(t2, p);
    p = 1686629713 - qmul(t2, p);
    p = qmul(t, p);
    if (p > 64'd1073741824) p = 64'd1073741824;
    return p;
  endfunction

  function automatic logic [17:0] sat18(longint v);
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v[17:0];
  endfunction

  function automatic vertex_t outline_vertex(logic [8:0] idx);
    vertex_t o;
    longint cap, r, n, cnt, ppc, sub, side, x, y, wr, hr, s, k, d, t, u, sa, ca;
    longint sv, cv, cx, cy;
    cap = maxp;
    if (cap > LIMIT) cap = LIMIT;
    r = rad;
    if (r < (cap << 4)) n = (r + 8) >> 4;
    else n = cap;
    cnt = 4 + 4 * n;
    ppc = n + 1;
    sub = idx % ppc;
    side = idx / ppc;
    x = 0;
    y = 0;
    o.oor = idx >= cnt;
    if (!o.oor) begin
      if (sub < 2) begin
        wr = 0;
        hr = 0;
        s = sub + side;
        if (side % 2 == 0) wr = r;
        else hr = r;
        if (side > 1) begin
          wr = -wr;
          hr = -hr;
        end
        if (sub == 1) begin
          wr = -wr;
          hr = -hr;
        end
        x = ((s > 0 && s < 3) ? longint'(wd) : 0) + wr;
        y = ((s > 1 && s < 4) ? longint'(ht) : 0) + hr;
      end else begin
        k = sub - 1;
        d = n - 1;
        t = (k << 30) / d;
        u = ((d - k) << 30) / d;
        sa = (qsine(t) * r + 64'd536870912) >>> 30;
        ca = (qsine(u) * r + 64'd536870912) >>> 30;
        case (side)
          0: begin sv = sa; cv = ca; end
          1: begin sv = ca; cv = -sa; end
          2: begin sv = -sa; cv = -ca; end
          default: begin sv = -ca; cv = sa; end
        endcase
        cx = (side < 2) ? longint'(wd) - r : r;
        cy = (side == 1 || side == 2) ? longint'(ht) - r : r;
        x = cx + sv;
        y = cy - cv;
      end
    end
    o.px = sat18(x);
    o.py = sat18(y);
    o.cnt = cnt[8:0];
    return o;
  endfunction

  task automatic write_reg(logic [1:0] a, logic [15:0] v);
    cfg_we <= 1;
    cfg_addr <= a;
    cfg_data <= v;
    @(posedge clk);
    case (a)
      REG_BOX_WIDTH: wd = v;
      REG_BOX_HEIGHT: ht = v;
      REG_CORNER_RADIUS: rad = v;
      default: maxp = v[6:0];
    endcase
  endtask

  task automatic set_shape(logic [15:0] w, logic [15:0] h, logic [15:0] r, logic [6:0] m);
    s_tvalid <= 0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
    write_reg(REG_BOX_WIDTH, w);
    write_reg(REG_BOX_HEIGHT, h);
    write_reg(REG_CORNER_RADIUS, r);
    write_reg(REG_MAX_POINTS, {9'd0, m});
    cfg_we <= 0;
  endtask

  task automatic send_index(logic [15:0] idx, logic chk, vertex_t v);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= idx;
    vertex_q.push_back(chk ? v : outline_vertex(idx[8:0]));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // receiver stall and result check
  always @(posedge clk) begin
    vertex_t e, a;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        a = {m_tdata[17:0], m_tdata[35:18], m_tdata[44:36], m_tuser};
        if (vertex_q.size() == 0) begin
          $display("%0t unexpected beat actual %h", $time, a);
          errors++;
        end else begin
          e = vertex_q.pop_front();
          if (a.px !== e.px || a.py !== e.py || a.cnt !== e.cnt || a.oor !== e.oor) begin
            $display("%0t expected x=%h y=%h cnt=%0d oor=%b actual x=%h y=%h cnt=%0d oor=%b",
                     $time, e.px, e.py, e.cnt, e.oor, a.px, a.py, a.cnt, a.oor);
            errors++;
          end
        end
      end
      m_tready <= $urandom_range(99) >= recv_idle;
    end
  end

  // watchdog on cycles with no accepted beat and no register write
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  dir_row_t dir_rows[$];

  initial begin
    vertex_t z;
    logic [15:0] w, h, r;
    logic [6:0] m;
    wd = 0; ht = 0; rad = 0; maxp = 10;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // after reset: n = 0, four points, all at the origin
    z = '{px: 0, py: 0, cnt: 4, oor: 0};
    dir_rows.push_back('{16'd0, 1, z});
    dir_rows.push_back('{16'd3, 1, z});
    z.oor = 1;
    dir_rows.push_back('{16'd4, 1, z});
    dir_rows.push_back('{16'd511, 1, z});
    foreach (dir_rows[i]) send_index(dir_rows[i].idx, dir_rows[i].chk, dir_rows[i].v);
    // rounded corners with arcs, cap saturation, one corner point, extremes
    set_shape(16'd1600, 16'd800, 16'd100, 7'd10);
    for (int i = 0; i < 10; i++) send_index(16'(i * 7), 0, z);
    set_shape(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'h7F);
    for (int i = 0; i < 6; i++) send_index(16'(i * 64 + 63), 0, z);
    send_index(16'd511, 0, z);
    send_index(16'd260, 0, z);
    set_shape(16'd0, 16'd0, 16'd24, 7'd64);
    for (int i = 0; i < 6; i++) send_index(16'(i), 0, z);
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle = 79; recv_idle = 13; end
      if (ph == 2) begin send_idle = 0; recv_idle = 0; end
      for (int g = 0; g < 4; g++) begin
        w = $urandom;
        h = $urandom;
        m = $urandom_range(4) == 0 ? 7'($urandom) : 7'($urandom_range(12));
        r = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(200));
        set_shape(w, h, r, m);
        for (int i = 0; i < 34; i++)
          send_index($urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(60)), 0, z);
      end
    end
    s_tvalid <= 0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
